>>> rtl/bvpi_pkg.sv
// Package for the bounding-volume pair intersect block.
// Holds widths, pair-kind codes, pipeline side structs and the output saturator.
package bvpi_pkg;

  localparam int CB   = 16;          // coordinate width
  localparam int FB   = 8;           // fraction bits
  localparam int VB   = 18;          // result component width
  localparam int FW   = 48;          // packed input field width
  localparam int DW   = CB + 1;      // centre difference
  localparam int LW   = CB + 1;      // root (centre distance)
  localparam int SQW  = 2 * CB + 2;  // squared distance
  localparam int RSW  = CB + 1;      // radius sum
  localparam int DSW  = CB + 3;      // signed distance minus radius sum
  localparam int PW   = 2 * CB + 4;  // d * dist product
  localparam int NW   = PW + 1;      // rounded dividend
  localparam int DDW  = LW + 1;      // doubled divisor
  localparam int QB   = CB + 3;      // quotient bits
  localparam int GW   = CB + 3;      // box gap / sphere-box vector
  localparam int SBQ  = 2 * GW + 2;  // sphere-box squared length
  localparam int SATW = QB + 1;      // widest value fed to the saturator

  typedef enum logic [1:0] {
    OP_SS = 2'd0,
    OP_BB = 2'd1,
    OP_SB = 2'd2,
    OP_BS = 2'd3
  } op_e;

  typedef logic signed [VB-1:0] vec_t;

  localparam vec_t VEC_MAX   = vec_t'((1 <<< (VB - 1)) - 1);
  localparam vec_t VEC_MIN   = vec_t'(-(1 <<< (VB - 1)));
  localparam vec_t VEC_UNSUP = vec_t'(-(1 <<< FB));

  typedef struct packed {
    op_e                   op;
    logic [2:0][DW-1:0]    d;
    logic signed [RSW-1:0] rsum;
    logic                  hit;
    logic [2:0][VB-1:0]    vec;
  } side_t;

  typedef struct packed {
    side_t      sd;
    logic       hss;
    logic       lz;
    logic [2:0] neg;
  } tail_t;

  function automatic vec_t sat_vec(input logic signed [SATW-1:0] v);
    vec_t r;
    if (v > SATW'(VEC_MAX)) begin
      r = VEC_MAX;
    end else if (v < SATW'(VEC_MIN)) begin
      r = VEC_MIN;
    end else begin
      r = VB'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/bvpi_in_if.sv
// Input channel: one volume pair per transfer.
// Depends on bvpi_pkg.
interface bvpi_in_if import bvpi_pkg::*;;
  logic          valid;
  logic          ready;
  logic [1:0]    op;
  logic [FW-1:0] a_center;
  logic [FW-1:0] a_size;
  logic [FW-1:0] b_center;
  logic [FW-1:0] b_size;

  modport source (output valid, op, a_center, a_size, b_center, b_size, input ready);
  modport sink   (input valid, op, a_center, a_size, b_center, b_size, output ready);
endinterface

>>> rtl/bvpi_out_if.sv
// Output channel: one intersection result per transfer.
// Depends on bvpi_pkg.
interface bvpi_out_if import bvpi_pkg::*;;
  logic          valid;
  logic          ready;
  logic          hit;
  logic [VB-1:0] vec_x;
  logic [VB-1:0] vec_y;
  logic [VB-1:0] vec_z;
  logic          unsupported;

  modport source (output valid, hit, vec_x, vec_y, vec_z, unsupported, input ready);
  modport sink   (input valid, hit, vec_x, vec_y, vec_z, unsupported, output ready);
endinterface

>>> rtl/bounding_volume_pair_intersect.sv
// Bounding-volume pair intersect: sphere-sphere, box-box and sphere-box tests.
// Depends on bvpi_pkg, bvpi_in_if, bvpi_out_if, bvpi_sqrt and bvpi_div.
//
// Usage:
//   in_i carries one volume pair and its pair kind per transfer; out_o carries
//   one result (hit flag, saturated Q10.8 vector, unsupported flag) per input.
//   Results leave in input order.
// Pipeline: from input transfer to output valid, three front stages
//   (unpack, squares, sums), 17 root stages, two stages for the signed distance
//   product and dividend, 19 quotient stages and the output register.
// Throughput: one pair per cycle while the output is not stalled; the bit-per-stage
//   root and divider pipelines set the depth, not the rate.
// Reset: clears every stage valid bit; the block is ready right after reset.
// Stall: when a result waits and out_o.ready is low, the whole pipeline holds
//   and in_i.ready drops; no item is lost or repeated. While the output stage
//   is empty or drains, the pipeline advances and accepts a new pair.
module bounding_volume_pair_intersect import bvpi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bvpi_in_if.sink    in_i,
  bvpi_out_if.source out_o
);

  logic en, acc;
  logic vout_q;

  assign en         = !vout_q || out_o.ready;
  assign in_i.ready = en;
  assign acc        = in_i.valid && en;

  // ---------------- stage 1: unpack, differences, box gaps, clamp
  logic signed [CB-1:0] ac [3], as [3], bc [3], bs [3];
  logic signed [DW-1:0] d1_d [3];
  logic signed [GW-1:0] bb1_d [3], sb1_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [GW-1:0] g1, g2, lo, hi, p;
      ac[i]   = signed'(in_i.a_center[i*CB +: CB]);
      as[i]   = signed'(in_i.a_size[i*CB +: CB]);
      bc[i]   = signed'(in_i.b_center[i*CB +: CB]);
      bs[i]   = signed'(in_i.b_size[i*CB +: CB]);
      d1_d[i] = DW'(bc[i]) - DW'(ac[i]);
      g1 = GW'(bc[i]) - GW'(bs[i]) - GW'(ac[i]) - GW'(as[i]);
      g2 = GW'(ac[i]) - GW'(as[i]) - GW'(bc[i]) - GW'(bs[i]);
      bb1_d[i] = (g1 > g2) ? g1 : g2;
      lo = GW'(bc[i]) - GW'(bs[i]);
      hi = GW'(bc[i]) + GW'(bs[i]);
      p  = (GW'(ac[i]) < hi) ? GW'(ac[i]) : hi;
      if (lo > p) begin
        p = lo;
      end
      sb1_d[i] = p - GW'(ac[i]);
    end
  end

  logic                  v1_q;
  op_e                   op1_q;
  logic signed [DW-1:0]  d1_q [3];
  logic signed [GW-1:0]  bb1_q [3], sb1_q [3];
  logic signed [RSW-1:0] rsum1_q;
  logic signed [CB-1:0]  r1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q   <= op_e'(in_i.op);
      d1_q    <= d1_d;
      bb1_q   <= bb1_d;
      sb1_q   <= sb1_d;
      rsum1_q <= RSW'(as[0]) + RSW'(bs[0]);
      r1_q    <= as[0];
    end
  end

  // ---------------- stage 2: squares, box maximum
  logic [SQW-1:0] sqd2_d [3];
  logic [SBQ-1:0] sbsq2_d [3];
  logic signed [GW-1:0] m2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [DW-1:0] md;
      logic [GW-1:0] mv;
      md = d1_q[i][DW-1] ? DW'(-d1_q[i]) : DW'(d1_q[i]);
      mv = sb1_q[i][GW-1] ? GW'(-sb1_q[i]) : GW'(sb1_q[i]);
      sqd2_d[i]  = SQW'(md) * SQW'(md);
      sbsq2_d[i] = SBQ'(mv) * SBQ'(mv);
    end
    m2 = bb1_q[0];
    if (bb1_q[1] > m2) begin
      m2 = bb1_q[1];
    end
    if (bb1_q[2] > m2) begin
      m2 = bb1_q[2];
    end
  end

  logic                  v2_q;
  op_e                   op2_q;
  logic signed [DW-1:0]  d2_q [3];
  logic signed [GW-1:0]  bb2_q [3], sb2_q [3];
  logic signed [RSW-1:0] rsum2_q;
  logic [SQW-1:0]        sqd2_q [3];
  logic [SBQ-1:0]        sbsq2_q [3];
  logic [SBQ-1:0]        r2_q;
  logic                  rpos2_q, bbhit2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q    <= op1_q;
      d2_q     <= d1_q;
      bb2_q    <= bb1_q;
      sb2_q    <= sb1_q;
      rsum2_q  <= rsum1_q;
      sqd2_q   <= sqd2_d;
      sbsq2_q  <= sbsq2_d;
      r2_q     <= SBQ'(unsigned'(r1_q[CB-2:0])) * SBQ'(unsigned'(r1_q[CB-2:0]));
      rpos2_q  <= (r1_q > 0);
      bbhit2_q <= m2[GW-1];
    end
  end

  // ---------------- stage 3: sums, non-sphere-sphere results
  side_t side3_d;
  logic [SBQ-1:0] sbsum3;

  always_comb begin
    sbsum3        = sbsq2_q[0] + sbsq2_q[1] + sbsq2_q[2];
    side3_d.op    = op2_q;
    side3_d.rsum  = rsum2_q;
    side3_d.hit   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      side3_d.d[i]   = d2_q[i];
      side3_d.vec[i] = VEC_UNSUP;
    end
    case (op2_q)
      OP_BB: begin
        side3_d.hit = bbhit2_q;
        for (int i = 0; i < 3; i++) begin
          side3_d.vec[i] = sat_vec(SATW'(bb2_q[i]));
        end
      end
      OP_SB: begin
        side3_d.hit = rpos2_q && (sbsum3 < r2_q);
        for (int i = 0; i < 3; i++) begin
          side3_d.vec[i] = sat_vec(SATW'(sb2_q[i]));
        end
      end
      default: begin
      end
    endcase
  end

  logic           v3_q;
  side_t          side3_q;
  logic [SQW-1:0] sq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side3_d;
      sq3_q   <= sqd2_q[0] + sqd2_q[1] + sqd2_q[2];
    end
  end

  // ---------------- root stages, side data delayed alongside
  logic [LW-1:0] len;
  side_t         sdl_q [LW];
  logic [LW-1:0] vsq_q;

  bvpi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq3_q),
    .root_o (len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsq_q <= '0;
    end else if (en) begin
      vsq_q <= {vsq_q[LW-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdl_q[0] <= side3_q;
      for (int s = 1; s < LW; s++) begin
        sdl_q[s] <= sdl_q[s-1];
      end
    end
  end

  // ---------------- stage 4: distance minus radius sum, products
  side_t                 sd_sq;
  logic signed [DSW-1:0] dist4;

  assign sd_sq = sdl_q[LW-1];
  assign dist4 = DSW'(signed'({1'b0, len})) - DSW'(sd_sq.rsum);

  logic                 v4_q;
  side_t                side4_q;
  logic [LW-1:0]        len4_q;
  logic                 hss4_q;
  logic signed [PW-1:0] prod4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vsq_q[LW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= sd_sq;
      len4_q  <= len;
      hss4_q  <= dist4[DSW-1];
      for (int i = 0; i < 3; i++) begin
        prod4_q[i] <= PW'(signed'(sd_sq.d[i])) * PW'(dist4);
      end
    end
  end

  // ---------------- stage 5: rounded dividend and doubled divisor
  logic           v5_q;
  tail_t          tail5_q;
  logic [NW-1:0]  num5_q [3];
  logic [DDW-1:0] den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail5_q.sd  <= side4_q;
      tail5_q.hss <= hss4_q;
      tail5_q.lz  <= (len4_q == '0);
      den5_q      <= {len4_q, 1'b0};
      for (int i = 0; i < 3; i++) begin
        tail5_q.neg[i] <= prod4_q[i][PW-1];
        num5_q[i] <= ((prod4_q[i][PW-1] ? NW'(-prod4_q[i]) : NW'(prod4_q[i])) << 1)
                     + NW'(len4_q);
      end
    end
  end

  // ---------------- quotient stages
  logic [QB-1:0] quo [3];
  tail_t         tdl_q [QB];
  logic [QB-1:0] vdv_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    bvpi_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num5_q[i]),
      .den_i (den5_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdv_q <= '0;
    end else if (en) begin
      vdv_q <= {vdv_q[QB-2:0], v5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdl_q[0] <= tail5_q;
      for (int s = 1; s < QB; s++) begin
        tdl_q[s] <= tdl_q[s-1];
      end
    end
  end

  // ---------------- output register
  tail_t tl;
  vec_t  vec_d [3];
  logic  hit_d;

  assign tl = tdl_q[QB-1];

  always_comb begin
    hit_d = tl.sd.hit;
    for (int i = 0; i < 3; i++) begin
      logic signed [SATW-1:0] q;
      q = tl.neg[i] ? -SATW'(quo[i]) : SATW'(quo[i]);
      vec_d[i] = tl.sd.vec[i];
      if (tl.sd.op == OP_SS) begin
        vec_d[i] = tl.lz ? '0 : sat_vec(q);
      end
    end
    if (tl.sd.op == OP_SS) begin
      hit_d = tl.hss;
    end
  end

  logic          hit_q, unsup_q;
  logic [VB-1:0] vx_q, vy_q, vz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= vdv_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_d;
      vx_q    <= vec_d[0];
      vy_q    <= vec_d[1];
      vz_q    <= vec_d[2];
      unsup_q <= (tl.sd.op == OP_BS);
    end
  end

  assign out_o.valid       = vout_q;
  assign out_o.hit         = hit_q;
  assign out_o.vec_x       = vx_q;
  assign out_o.vec_y       = vy_q;
  assign out_o.vec_z       = vz_q;
  assign out_o.unsupported = unsup_q;

  // ---------------- assertions
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted pair did not enter stage 1");

  a_tail_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vdv_q[QB-1]) |=> vout_q)
    else $error("quotient stage result did not reach the output register");

  a_unsup_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vout_q && unsup_q) |-> (!hit_q && vx_q == VEC_UNSUP && vy_q == VEC_UNSUP
                             && vz_q == VEC_UNSUP))
    else $error("unsupported pair result is wrong");

endmodule

>>> rtl/bvpi_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on bvpi_pkg.
module bvpi_sqrt import bvpi_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [SQW-1:0] rad_i,
  output logic [LW-1:0]  root_o
);

  logic [SQW-1:0] rem_q  [LW];
  logic [LW-1:0]  root_q [LW];

  for (genvar s = 0; s < LW; s++) begin : g_stage
    localparam int K = LW - 1 - s;
    logic [SQW-1:0] rem_in, rem_d;
    logic [LW-1:0]  root_in, root_d;
    logic [SQW:0]   trial;

    always_comb begin
      if (s == 0) begin
        rem_in  = rad_i;
        root_in = '0;
      end else begin
        rem_in  = rem_q[(s == 0) ? 0 : s - 1];
        root_in = root_q[(s == 0) ? 0 : s - 1];
      end
      trial  = ((SQW + 1)'(root_in) << (K + 1)) + ((SQW + 1)'(1) << (2 * K));
      rem_d  = rem_in;
      root_d = root_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_d     = SQW'({1'b0, rem_in} - trial);
        root_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  assign root_o = root_q[LW-1];

endmodule

>>> rtl/bvpi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bvpi_pkg.
module bvpi_div import bvpi_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DDW-1:0] den_i,
  output logic [QB-1:0]  quo_o
);

  logic [DDW-1:0] rem_q [QB];
  logic [NW-1:0]  num_q [QB];
  logic [DDW-1:0] den_q [QB];
  logic [QB-1:0]  quo_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [DDW-1:0] rem_in, rem_d, den_in;
    logic [NW-1:0]  num_in;
    logic [QB-1:0]  quo_in, quo_d;
    logic [DDW:0]   t;

    always_comb begin
      if (s == 0) begin
        rem_in = DDW'(num_i[NW-1:QB]);
        num_in = num_i;
        den_in = den_i;
        quo_in = '0;
      end else begin
        rem_in = rem_q[(s == 0) ? 0 : s - 1];
        num_in = num_q[(s == 0) ? 0 : s - 1];
        den_in = den_q[(s == 0) ? 0 : s - 1];
        quo_in = quo_q[(s == 0) ? 0 : s - 1];
      end
      t     = {rem_in, num_in[K]};
      rem_d = DDW'(t);
      quo_d = quo_in;
      if (t >= {1'b0, den_in}) begin
        rem_d    = DDW'(t - {1'b0, den_in});
        quo_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        num_q[s] <= num_in;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule
